// ----- hdl/tkbst_pkg.sv -----
// ----------------------------------------------------------------------------
// tkbst_pkg
// shared types and constants of the best-slot tracker
// ----------------------------------------------------------------------------
package tkbst_pkg;

  // population and list geometry
  localparam int unsigned POP_SIZE  = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned FIT_W     = 32;
  localparam int unsigned TRACK_MAX = 8;
  localparam int unsigned IDX_W     = $clog2(TRACK_MAX + 1);
  localparam int unsigned RIDX_W    = (TRACK_MAX > 1) ? $clog2(TRACK_MAX) : 1;
  localparam int unsigned CFG_W     = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_LISTED   = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef logic [TRACK_MAX-1:0][SLOT_W-1:0] rank_arr_t;

  // sequencer to list commands
  typedef struct packed {
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_val;
    logic              shift;
    logic              place;
    logic [RIDX_W-1:0] idx;
    logic [SLOT_W-1:0] slot;
  } list_cmd_t;

  // list status back to the sequencer
  typedef struct packed {
    rank_arr_t        rank;
    logic [IDX_W-1:0] fill;
    logic [IDX_W-1:0] lim;
    logic             full;
  } list_stat_t;

endpackage

// ----- hdl/tkbst_ram.sv -----
// ----------------------------------------------------------------------------
// tkbst_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module tkbst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tkbst_list.sv -----
// ----------------------------------------------------------------------------
// tkbst_list
// ranked slot list, protect lookup, fill count and list limit
// ----------------------------------------------------------------------------
module tkbst_list
  import tkbst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  list_cmd_t         cmd_i,
  input  logic [SLOT_W-1:0] query_slot_i,
  output logic              protect_o,
  output list_stat_t        stat_o
);

  localparam logic [IDX_W-1:0] LimMax = IDX_W'(TRACK_MAX);
  localparam logic [IDX_W-1:0] LimRst = (TRACK_MAX < 8) ? IDX_W'(TRACK_MAX) : IDX_W'(8);

  rank_arr_t             rank_q, rank_d;
  logic [IDX_W-1:0]      fill_q, fill_d;
  logic [IDX_W-1:0]      lim_q, lim_d;
  logic [IDX_W-1:0]      new_lim;
  logic                  full;
  logic                  listed_hit;

  // clamp the written limit into 1..TRACK_MAX
  always_comb begin
    if (cmd_i.cfg_val == '0) begin
      new_lim = IDX_W'(1);
    end else if (IDX_W'(cmd_i.cfg_val) > LimMax) begin
      new_lim = LimMax;
    end else begin
      new_lim = IDX_W'(cmd_i.cfg_val);
    end
  end

  assign full = (fill_q >= lim_q);

  // a slot is protected exactly while it sits below the fill count
  always_comb begin
    listed_hit = 1'b0;
    for (int j = 0; j < TRACK_MAX; j++) begin
      if (IDX_W'(j) < fill_q && rank_q[j] == query_slot_i) begin
        listed_hit = 1'b1;
      end
    end
  end

  // list updates
  always_comb begin
    rank_d = rank_q;
    fill_d = fill_q;
    lim_d  = lim_q;
    // limit write drops ranks beyond the new limit
    if (cmd_i.cfg_we) begin
      lim_d = new_lim;
      if (fill_q > new_lim) begin
        fill_d = new_lim;
      end
    end
    // move one entry down by one rank
    if (cmd_i.shift) begin
      rank_d[cmd_i.idx] = rank_q[cmd_i.idx - RIDX_W'(1)];
    end
    if (cmd_i.place) begin
      rank_d[cmd_i.idx] = cmd_i.slot;
      if (!full) begin
        fill_d = fill_q + IDX_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      lim_q  <= LimRst;
    end else begin
      fill_q <= fill_d;
      lim_q  <= lim_d;
    end
  end

  // ranked slots, valid below the fill count only
  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
  end

  assign protect_o   = listed_hit;
  assign stat_o.rank = rank_q;
  assign stat_o.fill = fill_q;
  assign stat_o.lim  = lim_q;
  assign stat_o.full = full;

endmodule

// ----- hdl/top_k_best_slot_tracker_top.sv -----
// ----------------------------------------------------------------------------
// top_k_best_slot_tracker_top
// keeps a descending list of the best-scored population slots
// ----------------------------------------------------------------------------
// sequence: a rejected transfer passes S_BEST and S_OUT; a stored one first
//   walks the list in S_CMP, one score-store read per rank compared on the
//   single read port (0..track_count ranks), and a listed one then passes S_PLACE
// in_ready_o is high only in S_IDLE, so a new item is taken only once S_OUT
//   has loaded the result of the last one into the free result register
// reset: list empty, protect map clear, track_count at 8, no result pending
// ----------------------------------------------------------------------------
module top_k_best_slot_tracker_top
  import tkbst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SLOT_W-1:0]       slot_i,
  input  logic signed [FIT_W-1:0] new_fitness_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [2:0]              position_o,
  output logic                    evicted_valid_o,
  output logic [SLOT_W-1:0]       evicted_slot_o,
  output logic [SLOT_W-1:0]       best_slot_o,
  output logic signed [FIT_W-1:0] best_fitness_o,
  output logic [3:0]              fill_count_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic REG_TRACK_COUNT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_BEST,
    S_OUT
  } state_e;

  state_e                    state_q, state_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic signed [FIT_W-1:0]   fit_q, fit_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic                      first_q, first_d;
  status_e                   status_q, status_d;
  logic                      ev_valid_q, ev_valid_d;
  logic [SLOT_W-1:0]         ev_slot_q, ev_slot_d;
  logic [RIDX_W-1:0]         pos_q, pos_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                o_status_q, o_status_d;
  logic [2:0]                o_pos_q, o_pos_d;
  logic                      o_ev_valid_q, o_ev_valid_d;
  logic [SLOT_W-1:0]         o_ev_slot_q, o_ev_slot_d;
  logic [SLOT_W-1:0]         o_best_slot_q, o_best_slot_d;
  logic signed [FIT_W-1:0]   o_best_fit_q, o_best_fit_d;
  logic [3:0]                o_fill_q, o_fill_d;

  list_cmd_t                 cmd;
  list_stat_t                stat;
  logic                      protect;
  logic                      cfg_we;

  logic                      ram_we;
  logic                      ram_re;
  logic [SLOT_W-1:0]         ram_raddr;
  logic [FIT_W-1:0]          ram_rdata;
  logic signed [FIT_W-1:0]   score;

  logic [IDX_W-1:0]          start_idx;
  logic [IDX_W-1:0]          start_m1;
  logic [IDX_W-1:0]          idx_m1;
  logic [IDX_W-1:0]          idx_m2;

  // configuration port
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_TRACK_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRACK_COUNT) ? 32'(stat.lim) : '0;

  // list walk cursors
  assign start_idx = stat.full ? stat.lim : stat.fill;
  assign start_m1  = start_idx - IDX_W'(1);
  assign idx_m1    = idx_q - IDX_W'(1);
  assign idx_m2    = idx_q - IDX_W'(2);
  assign score     = $signed(ram_rdata);

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer next state
  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    fit_d         = fit_q;
    idx_d         = idx_q;
    first_d       = first_q;
    status_d      = status_q;
    ev_valid_d    = ev_valid_q;
    ev_slot_d     = ev_slot_q;
    pos_d         = pos_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    o_status_d    = o_status_q;
    o_pos_d       = o_pos_q;
    o_ev_valid_d  = o_ev_valid_q;
    o_ev_slot_d   = o_ev_slot_q;
    o_best_slot_d = o_best_slot_q;
    o_best_fit_d  = o_best_fit_q;
    o_fill_d      = o_fill_q;

    cmd         = '0;
    cmd.cfg_we  = cfg_we;
    cmd.cfg_val = pwdata[CFG_W-1:0];
    cmd.slot    = slot_q;
    cmd.idx     = idx_q[RIDX_W-1:0];

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = stat.rank[idx_m2[RIDX_W-1:0]];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d     = slot_i;
          fit_d      = new_fitness_i;
          first_d    = 1'b1;
          ev_valid_d = 1'b0;
          ev_slot_d  = '0;
          pos_d      = '0;
          idx_d      = start_idx;
          if (protect) begin
            status_d = ST_REJECTED;
            state_d  = S_BEST;
          end else begin
            // store the score, then start at the lowest occupied rank
            status_d = ST_STORED;
            ram_we   = 1'b1;
            if (start_idx == '0) begin
              state_d = S_PLACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = stat.rank[start_m1[RIDX_W-1:0]];
              state_d   = S_CMP;
            end
          end
        end
      end
      S_CMP: begin
        // read of the next rank up is issued ahead of the compare result
        ram_re = 1'b1;
        if (first_q && stat.full) begin
          first_d = 1'b0;
          if (score >= fit_q) begin
            state_d = S_BEST;
          end else begin
            ev_valid_d = 1'b1;
            ev_slot_d  = stat.rank[idx_m1[RIDX_W-1:0]];
            idx_d      = idx_m1;
            if (idx_m1 == '0) begin
              state_d = S_PLACE;
            end
          end
        end else if (score > fit_q) begin
          state_d = S_PLACE;
        end else begin
          cmd.shift = 1'b1;
          idx_d     = idx_m1;
          if (idx_m1 == '0) begin
            state_d = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        status_d  = ST_LISTED;
        pos_d     = idx_q[RIDX_W-1:0];
        state_d   = S_BEST;
      end
      S_BEST: begin
        ram_re    = 1'b1;
        ram_raddr = stat.rank[0];
        state_d   = S_OUT;
      end
      S_OUT: begin
        // load the result register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          o_status_d   = status_q;
          o_pos_d      = 3'(pos_q);
          o_ev_valid_d = ev_valid_q;
          o_ev_slot_d  = ev_slot_q;
          o_fill_d     = 4'(stat.fill);
          if (stat.fill != '0) begin
            o_best_slot_d = stat.rank[0];
            o_best_fit_d  = score;
          end else begin
            o_best_slot_d = '0;
            o_best_fit_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_q        <= '0;
      fit_q         <= '0;
      idx_q         <= '0;
      first_q       <= 1'b0;
      status_q      <= ST_STORED;
      ev_valid_q    <= 1'b0;
      ev_slot_q     <= '0;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
      o_status_q    <= '0;
      o_pos_q       <= '0;
      o_ev_valid_q  <= 1'b0;
      o_ev_slot_q   <= '0;
      o_best_slot_q <= '0;
      o_best_fit_q  <= '0;
      o_fill_q      <= '0;
    end else begin
      state_q       <= state_d;
      slot_q        <= slot_d;
      fit_q         <= fit_d;
      idx_q         <= idx_d;
      first_q       <= first_d;
      status_q      <= status_d;
      ev_valid_q    <= ev_valid_d;
      ev_slot_q     <= ev_slot_d;
      pos_q         <= pos_d;
      out_valid_q   <= out_valid_d;
      o_status_q    <= o_status_d;
      o_pos_q       <= o_pos_d;
      o_ev_valid_q  <= o_ev_valid_d;
      o_ev_slot_q   <= o_ev_slot_d;
      o_best_slot_q <= o_best_slot_d;
      o_best_fit_q  <= o_best_fit_d;
      o_fill_q      <= o_fill_d;
    end
  end

  // score store
  tkbst_ram #(
    .WIDTH (FIT_W),
    .DEPTH (POP_SIZE)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_i),
    .wdata_i (new_fitness_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ranked list and protect lookup
  tkbst_list u_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .query_slot_i (slot_i),
    .protect_o    (protect),
    .stat_o       (stat)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign position_o      = o_pos_q;
  assign evicted_valid_o = o_ev_valid_q;
  assign evicted_slot_o  = o_ev_slot_q;
  assign best_slot_o     = o_best_slot_q;
  assign best_fitness_o  = o_best_fit_q;
  assign fill_count_o    = o_fill_q;

  // the list never holds more entries than the limit
  a_fill_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fill <= stat.lim)
    else $error("list fill exceeds limit");

  // an eviction is only reported with a listed item
  a_evict_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_valid_o) |-> (status_o == ST_LISTED))
    else $error("eviction without listing");

  // every result follows a list that holds at least one slot
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o != '0))
    else $error("result with empty list");

  // a comparison step never runs with the cursor at rank zero
  a_cursor_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (idx_q != '0))
    else $error("list walk past rank zero");

endmodule
